FILE: rtl/core/ray_sphere_hit_test_top_assert.svh
// assertion helpers, sampled on clk, off during reset
`ifndef RAY_SPHERE_HIT_TEST_TOP_ASSERT_SVH
`define RAY_SPHERE_HIT_TEST_TOP_ASSERT_SVH

// condition implies check in the same cycle
`define RSH_CHK_NOW(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) else $error(msg);

// condition implies check in the next cycle
`define RSH_CHK_NEXT(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) else $error(msg);

`endif

FILE: rtl/core/rsh_pkg.sv
package rsh_pkg;

	localparam int CW     = 24;
	localparam int RADW   = 23;
	localparam int NS     = RADW;
	localparam int SQW    = 2 * NS + 2;
	localparam int SIN_LAT = 7;

	localparam logic [30:0] Q30_ONE = 31'h4000_0000;
	localparam logic [30:0] SC1 = 31'd1686629713;
	localparam logic [30:0] SC3 = 31'd693598668;
	localparam logic [30:0] SC5 = 31'd85569306;
	localparam logic [30:0] SC7 = 31'd5026995;
	localparam logic [30:0] SC9 = 31'd172272;

	typedef struct packed {
		logic        neg;
		logic [30:0] mag;
	} sin_out_t;

endpackage

FILE: rtl/core/ray_sphere_hit_test_top.sv
// Geometric ray/sphere hit test. One ray per cycle on s_* when the output side
// keeps up; each result leaves on m_* after the seven-stage sine pipeline, the
// direction, dot-product and distance stages, and the square root, which
// resolves one result bit per stage over 23 stages. A stall on m_tready holds
// the whole pipeline.
`include "ray_sphere_hit_test_top_assert.svh"

module ray_sphere_hit_test_top import rsh_pkg::*; #(
	parameter int ANGLE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// origin_x, origin_y, origin_z, view_pitch, view_yaw,
	// center_x, center_y, center_z, sphere_radius, zero fill
	input  logic [(6 * CW + 2 * ANGLE_BITS + RADW + 7) / 8 * 8 - 1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// hit, hit_distance, zero fill
	output logic [31:0] m_tdata
);

	localparam int PSH   = 32 - ANGLE_BITS;
	localparam int OFS_P = 3 * CW;
	localparam int OFS_Y = OFS_P + ANGLE_BITS;
	localparam int OFS_C = OFS_Y + ANGLE_BITS;
	localparam int OFS_R = OFS_C + 3 * CW;
	localparam int LAT   = 14 + NS;
	localparam logic signed [31:0] DIR_ONE = 32'sh4000_0000;

	logic           en;
	logic [LAT-1:0] vld_q;

	logic signed [CW-1:0] ox, oy, oz, cx, cy, cz;
	logic [ANGLE_BITS-1:0] pitch, yaw;
	logic [31:0] pp, pw, pp_c, pw_c;

	assign ox    = s_tdata[0 +: CW];
	assign oy    = s_tdata[CW +: CW];
	assign oz    = s_tdata[2*CW +: CW];
	assign pitch = s_tdata[OFS_P +: ANGLE_BITS];
	assign yaw   = s_tdata[OFS_Y +: ANGLE_BITS];
	assign cx    = s_tdata[OFS_C +: CW];
	assign cy    = s_tdata[OFS_C+CW +: CW];
	assign cz    = s_tdata[OFS_C+2*CW +: CW];

	assign pp   = {pitch, {PSH{1'b0}}};
	assign pw   = {~yaw[ANGLE_BITS-1], yaw[ANGLE_BITS-2:0], {PSH{1'b0}}};
	assign pp_c = pp + 32'h4000_0000;
	assign pw_c = pw + 32'h4000_0000;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	sin_out_t sp, cp, sw, cw;

	rsh_sin u_sin_p (.clk(clk), .en(en), .phase(pp),   .res(sp));
	rsh_sin u_cos_p (.clk(clk), .en(en), .phase(pp_c), .res(cp));
	rsh_sin u_sin_w (.clk(clk), .en(en), .phase(pw),   .res(sw));
	rsh_sin u_cos_w (.clk(clk), .en(en), .phase(pw_c), .res(cw));

	// offset and radius ride alongside the sine pipeline
	logic signed [CW:0] lx_s [1:SIN_LAT];
	logic signed [CW:0] ly_s [1:SIN_LAT];
	logic signed [CW:0] lz_s [1:SIN_LAT];
	logic [RADW-1:0]    r_s  [1:SIN_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			lx_s[1] <= $signed({cx[CW-1], cx}) - $signed({ox[CW-1], ox});
			ly_s[1] <= $signed({cy[CW-1], cy}) - $signed({oy[CW-1], oy});
			lz_s[1] <= $signed({cz[CW-1], cz}) - $signed({oz[CW-1], oz});
			r_s[1]  <= s_tdata[OFS_R +: RADW];
			for (int i = 2; i <= SIN_LAT; i++) begin
				lx_s[i] <= lx_s[i-1];
				ly_s[i] <= ly_s[i-1];
				lz_s[i] <= lz_s[i-1];
				r_s[i]  <= r_s[i-1];
			end
		end
	end

	// direction
	logic [61:0] mx, mz;
	logic signed [31:0] dxm, dzm, dym;
	logic signed [31:0] dx_s8, dy_s8, dz_s8;
	logic signed [CW:0] lx_s8, ly_s8, lz_s8;
	logic [RADW-1:0]    r_s8;

	assign mx  = cp.mag * sw.mag;
	assign mz  = cp.mag * cw.mag;
	assign dxm = {1'b0, mx[60:30]};
	assign dzm = {1'b0, mz[60:30]};
	assign dym = {1'b0, sp.mag};

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s8 <= (cp.neg ^ sw.neg) ? -dxm : dxm;
			dz_s8 <= (cp.neg ^ cw.neg) ? -dzm : dzm;
			dy_s8 <= sp.neg ? -dym : dym;
			lx_s8 <= lx_s[SIN_LAT];
			ly_s8 <= ly_s[SIN_LAT];
			lz_s8 <= lz_s[SIN_LAT];
			r_s8  <= r_s[SIN_LAT];
		end
	end

	// products
	logic signed [56:0] px_s9, py_s9, pz_s9;
	logic signed [49:0] qx_s9, qy_s9, qz_s9;
	logic [2*RADW-1:0]  r2_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s9 <= lx_s8 * dx_s8;
			py_s9 <= ly_s8 * dy_s8;
			pz_s9 <= lz_s8 * dz_s8;
			qx_s9 <= lx_s8 * lx_s8;
			qy_s9 <= ly_s8 * ly_s8;
			qz_s9 <= lz_s8 * lz_s8;
			r2_s9 <= r_s8 * r_s8;
		end
	end

	// sums
	logic signed [58:0] dot_s10;
	logic signed [51:0] ll_s10;
	logic [2*RADW-1:0]  r2_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			dot_s10 <= px_s9 + py_s9 + pz_s9;
			ll_s10  <= qx_s9 + qy_s9 + qz_s9;
			r2_s10  <= r2_s9;
		end
	end

	// projection and its square
	logic [25:0]        tca_c;
	logic [25:0]        tca_s11;
	logic [51:0]        tca2_s11;
	logic               neg_s11;
	logic signed [51:0] ll_s11;
	logic [2*RADW-1:0]  r2_s11;

	assign tca_c = dot_s10[55:30];

	always_ff @(posedge clk) begin
		if (en) begin
			tca_s11  <= tca_c;
			tca2_s11 <= tca_c * tca_c;
			neg_s11  <= dot_s10[58];
			ll_s11   <= ll_s10;
			r2_s11   <= r2_s10;
		end
	end

	// squared distance of centre from the ray, clamped at zero
	logic signed [52:0] d2_c;
	logic [51:0]        d2_s12;
	logic [25:0]        tca_s12;
	logic               neg_s12;
	logic [2*RADW-1:0]  r2_s12;

	assign d2_c = $signed({ll_s11[51], ll_s11}) - $signed({1'b0, tca2_s11});

	always_ff @(posedge clk) begin
		if (en) begin
			d2_s12  <= d2_c[52] ? 52'd0 : d2_c[51:0];
			tca_s12 <= tca_s11;
			neg_s12 <= neg_s11;
			r2_s12  <= r2_s11;
		end
	end

	logic [2*RADW-1:0] v_s13;
	logic [25:0]       tca_s13;
	logic              miss_s13;

	always_ff @(posedge clk) begin
		if (en) begin
			miss_s13 <= neg_s12 || (d2_s12 > {{(52-2*RADW){1'b0}}, r2_s12});
			v_s13    <= r2_s12 - d2_s12[2*RADW-1:0];
			tca_s13  <= tca_s12;
		end
	end

	// square root, one result bit per stage
	logic [SQW-1:0] sq_rem_s  [1:NS];
	logic [SQW-1:0] sq_res_s  [1:NS];
	logic [25:0]    sq_tca_s  [1:NS];
	logic           sq_miss_s [1:NS];

	for (genvar k = 0; k < NS; k++) begin : g_sq
		localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (NS - 1 - k));
		logic [SQW-1:0] rin, qin, trial;
		logic [25:0]    tin;
		logic           min;

		if (k == 0) begin : g_first
			assign rin = {{(SQW-2*RADW){1'b0}}, v_s13};
			assign qin = '0;
			assign tin = tca_s13;
			assign min = miss_s13;
		end else begin : g_rest
			assign rin = sq_rem_s[k];
			assign qin = sq_res_s[k];
			assign tin = sq_tca_s[k];
			assign min = sq_miss_s[k];
		end

		assign trial = qin + BIT;

		always_ff @(posedge clk) begin
			if (en) begin
				if (rin >= trial) begin
					sq_rem_s[k+1] <= rin - trial;
					sq_res_s[k+1] <= (qin >> 1) + BIT;
				end else begin
					sq_rem_s[k+1] <= rin;
					sq_res_s[k+1] <= qin >> 1;
				end
				sq_tca_s[k+1]  <= tin;
				sq_miss_s[k+1] <= min;
			end
		end
	end

	// nearest hit, saturated
	logic signed [27:0] t_c;
	logic               out_hit_q;
	logic [CW-1:0]      out_dist_q;

	assign t_c = $signed({2'b00, sq_tca_s[NS]})
		- $signed({5'b00000, sq_res_s[NS][RADW-1:0]});

	always_ff @(posedge clk) begin
		if (en) begin
			out_hit_q <= !sq_miss_s[NS];
			if (sq_miss_s[NS]) begin
				out_dist_q <= '0;
			end else if (t_c > 28'sd8388607) begin
				out_dist_q <= 24'h7F_FFFF;
			end else if (t_c < -28'sd8388608) begin
				out_dist_q <= 24'h80_0000;
			end else begin
				out_dist_q <= t_c[CW-1:0];
			end
		end
	end

	assign m_tdata = {7'd0, out_dist_q, out_hit_q};

	`RSH_CHK_NOW(a_miss_zero, m_tvalid && !m_tdata[0], m_tdata[24:1] == 24'd0, "miss with distance")
	`RSH_CHK_NOW(a_dir_range, vld_q[7], (dy_s8 <= DIR_ONE) && (dy_s8 >= -DIR_ONE), "direction out of range")
	`RSH_CHK_NEXT(a_stall_hold, !en, $stable(vld_q), "pipeline moved during stall")

endmodule

FILE: rtl/core/rsh_sin.sv
module rsh_sin import rsh_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] phase,
	output sin_out_t    res
);

	logic [1:0]  quad_s1, quad_s2, quad_s3, quad_s4, quad_s5, quad_s6;
	logic [30:0] x_s1, x_s2, x_s3, x_s4, x_s5, x_s6;
	logic [30:0] u2_s2, u2_s3, u2_s4, u2_s5;
	logic [30:0] c7_s3, c5_s4, c3_s5, c1_s6;
	sin_out_t    res_s7;
	logic [61:0] m_u2, m9, m7, m5, m3, m1;

	assign m_u2 = x_s1 * x_s1;
	assign m9   = SC9 * u2_s2;
	assign m7   = c7_s3 * u2_s3;
	assign m5   = c5_s4 * u2_s4;
	assign m3   = c3_s5 * u2_s5;
	assign m1   = c1_s6 * x_s6;

	// quarter-wave Taylor sine, one Horner term per stage
	always_ff @(posedge clk) begin
		if (en) begin
			quad_s1 <= phase[31:30];
			x_s1    <= phase[30] ? (Q30_ONE - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
			quad_s2 <= quad_s1;
			x_s2    <= x_s1;
			u2_s2   <= m_u2[60:30];
			quad_s3 <= quad_s2;
			x_s3    <= x_s2;
			u2_s3   <= u2_s2;
			c7_s3   <= SC7 - m9[60:30];
			quad_s4 <= quad_s3;
			x_s4    <= x_s3;
			u2_s4   <= u2_s3;
			c5_s4   <= SC5 - m7[60:30];
			quad_s5 <= quad_s4;
			x_s5    <= x_s4;
			u2_s5   <= u2_s4;
			c3_s5   <= SC3 - m5[60:30];
			quad_s6 <= quad_s5;
			x_s6    <= x_s5;
			c1_s6   <= SC1 - m3[60:30];
			res_s7.neg <= quad_s6[1];
			res_s7.mag <= (m1[61:30] > {1'b0, Q30_ONE}) ? Q30_ONE : m1[60:30];
		end
	end

	assign res = res_s7;

endmodule
